[rtl/core/hpp_pkg.sv]
// Package for the heater PID controller: payload structs, register codes, constants.
// No dependencies.
`timescale 1ns / 1ps
package hpp_pkg;

  typedef struct packed {
    logic [9:0]         setpoint;
    logic signed [15:0] sensor_q4;
    logic [19:0]        elapsed_us;
  } in_item_t;

  typedef struct packed {
    logic [7:0] duty;
    logic       clamped;
  } out_item_t;

  localparam logic [1:0] REG_GAIN_PROP  = 2'd0;
  localparam logic [1:0] REG_GAIN_INTEG = 2'd1;
  localparam logic [1:0] REG_GAIN_DERIV = 2'd2;

  localparam int unsigned US_PER_S = 1000000;
  localparam int unsigned DUTY_MAX = 255;

  // Shift-add multiplier width: 48-bit multiplicand by 24-bit multiplier
  localparam int MUL_A_W = 48;
  localparam int MUL_B_W = 24;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int MUL_CNT_W = 5;

  // Divider: up to 72-bit dividend, 21-bit divisor
  localparam int DIV_N_W = 72;
  localparam int DIV_D_W = 21;
  localparam int DIV_CNT_W = 7;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } unit_ctl_t;

endpackage

[rtl/core/hpp_mul.sv]
// Bit-serial signed shift-add multiplier, one multiplier bit per cycle.
// Depends on hpp_pkg.
`timescale 1ns / 1ps
module hpp_mul
  import hpp_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic signed [MUL_A_W-1:0]  a,
  input  logic signed [MUL_B_W-1:0]  b,
  output logic                       done,
  output logic signed [MUL_P_W-1:0]  prod
);

  logic                      busy;
  logic [MUL_CNT_W-1:0]      cnt;
  logic signed [MUL_P_W-1:0] acc;
  logic signed [MUL_P_W-1:0] mcand;
  logic [MUL_B_W-1:0]        mplier;
  logic signed [MUL_P_W-1:0] acc_next;

  // add or (for the sign bit) subtract the shifted multiplicand
  always_comb begin
    acc_next = acc;
    if (mplier[0]) begin
      if (cnt == MUL_CNT_W'(MUL_B_W - 1)) acc_next = acc - mcand;
      else acc_next = acc + mcand;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == MUL_CNT_W'(MUL_B_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc    <= '0;
      mcand  <= MUL_P_W'(a);
      mplier <= b;
    end else if (busy) begin
      acc    <= acc_next;
      mcand  <= mcand <<< 1;
      mplier <= mplier >> 1;
    end
  end

  assign prod = acc;

endmodule

[rtl/core/hpp_div.sv]
// Bit-serial restoring divider, signed dividend, positive divisor,
// quotient truncated toward zero, remainder with the dividend's sign.
// Depends on hpp_pkg.
`timescale 1ns / 1ps
module hpp_div
  import hpp_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic signed [DIV_N_W-1:0] num,
  input  logic [DIV_D_W-1:0]        den,
  output logic                      done,
  output logic signed [DIV_N_W-1:0] quo,
  output logic signed [DIV_N_W-1:0] rem
);

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 neg;
  logic [DIV_N_W-1:0]   q;
  logic [DIV_D_W:0]     r;
  logic [DIV_D_W-1:0]   d;
  logic [DIV_D_W:0]     r_sh;
  logic [DIV_D_W:0]     r_sub;

  // one quotient bit a cycle
  always_comb begin
    r_sh  = {r[DIV_D_W-1:0], q[DIV_N_W-1]};
    r_sub = r_sh - {1'b0, d};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_N_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= num[DIV_N_W-1];
      q   <= num[DIV_N_W-1] ? DIV_N_W'(-num) : DIV_N_W'(num);
      r   <= '0;
      d   <= den;
    end else if (busy) begin
      if (!r_sub[DIV_D_W]) begin
        r <= r_sub;
        q <= {q[DIV_N_W-2:0], 1'b1};
      end else begin
        r <= r_sh;
        q <= {q[DIV_N_W-2:0], 1'b0};
      end
    end
  end

  assign quo = neg ? -$signed(q) : $signed(q);
  assign rem = neg ? -$signed(DIV_N_W'(r)) : $signed(DIV_N_W'(r));

endmodule

[rtl/core/heater_pid_pwm.sv]
// Top level of the heater PID controller with clamped PWM duty.
// Depends on hpp_pkg, hpp_mul and hpp_div.
`timescale 1ns / 1ps
//  channel | direction | handshake     | payload
//  in      | in        | valid / stall | in_item_t (target, measured, elapsed)
//  out     | out       | valid / stall | out_item_t (duty, clamped)
//  cfg     | in        | valid / ready | index (2 bits), 24-bit gain
//
// An item makes six passes of the shared multiplier and three of the divider
// (two when the elapsed time is zero and the derivative is skipped), plus the
// integral step, loading the result and returning to idle; no new item is
// taken before the sequencer is back in idle.
// Reset clears gains, integral and last error; no clearing pass.
// The result waits in an output register; the next item is taken while
// it waits, but is not finished until that register is free.
module heater_pid_pwm
  import hpp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MINT  = 4'd1;
  localparam logic [3:0] S_INTEG = 4'd2;
  localparam logic [3:0] S_DDIV  = 4'd3;
  localparam logic [3:0] S_IDIV  = 4'd4;
  localparam logic [3:0] S_MQ    = 4'd5;
  localparam logic [3:0] S_MR    = 4'd6;
  localparam logic [3:0] S_RDIV  = 4'd7;
  localparam logic [3:0] S_MP    = 4'd8;
  localparam logic [3:0] S_MD    = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;
  localparam logic [3:0] S_EMIT  = 4'd11;

  localparam logic signed [47:0] INTEG_MAX = {1'b0, {47{1'b1}}};
  localparam logic signed [47:0] INTEG_MIN = {1'b1, {47{1'b0}}};

  logic [3:0] state;
  logic signed [23:0] gain_prop, gain_integ, gain_deriv;
  logic signed [47:0] integral_sum;
  logic signed [16:0] last_error;
  logic signed [16:0] err;
  logic [19:0]        dt;
  logic signed [71:0] sum;
  logic signed [47:0] deriv;
  logic signed [47:0] ir;
  logic               clamp;
  logic               emit;

  logic                      mul_start, mul_done;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] mul_p;
  logic                      div_start, div_done;
  logic signed [DIV_N_W-1:0] div_n;
  logic [DIV_D_W-1:0]        div_d;
  logic signed [DIV_N_W-1:0] div_q, div_r;

  logic signed [16:0] err_in;
  logic signed [49:0] integ_sum;
  logic signed [71:0] sum_fin;

  hpp_mul u_mul (.clk, .rst, .start(mul_start), .a(mul_a), .b(mul_b),
                 .done(mul_done), .prod(mul_p));
  hpp_div u_div (.clk, .rst, .start(div_start), .num(div_n), .den(div_d),
                 .done(div_done), .quo(div_q), .rem(div_r));

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE) && !out_valid;

  // result register can take the finished item
  assign emit = (state == S_EMIT) && (!out_valid || !out_stall);

  assign err_in = $signed({3'b0, in_data.setpoint, 4'b0})
                - 17'(in_data.sensor_q4);
  assign integ_sum = 50'(integral_sum) + 50'(mul_p);
  assign sum_fin   = sum + mul_p;

  // floor correction for a truncating divide of a signed value
  function automatic logic signed [71:0] floor_q(input logic signed [71:0] q,
                                                  input logic signed [71:0] r);
    floor_q = (r < 0) ? q - 72'sd1 : q;
  endfunction

  // sequencer over shared multiplier and divider
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      out_valid    <= 1'b0;
      mul_start    <= 1'b0;
      div_start    <= 1'b0;
      gain_prop    <= '0;
      gain_integ   <= '0;
      gain_deriv   <= '0;
      integral_sum <= '0;
      last_error   <= '0;
    end else begin
      mul_start <= 1'b0;
      div_start <= 1'b0;
      if (emit) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_GAIN_PROP:  gain_prop  <= cfg_data;
          REG_GAIN_INTEG: gain_integ <= cfg_data;
          REG_GAIN_DERIV: gain_deriv <= cfg_data;
          default: ;
        endcase
      end
      case (state)
        S_IDLE: if (in_valid) begin
          err       <= err_in;
          dt        <= in_data.elapsed_us;
          clamp     <= 1'b0;
          mul_a     <= 48'(err_in);
          mul_b     <= 24'($signed({4'b0, in_data.elapsed_us}));
          mul_start <= 1'b1;
          state     <= S_MINT;
        end
        S_MINT: if (mul_done) begin
          if (integ_sum > 50'(INTEG_MAX)) begin
            integral_sum <= INTEG_MAX;
            clamp        <= 1'b1;
          end else if (integ_sum < 50'(INTEG_MIN)) begin
            integral_sum <= INTEG_MIN;
            clamp        <= 1'b1;
          end else begin
            integral_sum <= 48'(integ_sum);
          end
          state <= S_INTEG;
        end
        S_INTEG: begin
          // derivative numerator (err - last) * 1e6
          mul_a     <= 48'(err) - 48'(last_error);
          mul_b     <= 24'(US_PER_S);
          mul_start <= 1'b1;
          last_error <= err;
          state     <= S_DDIV;
        end
        S_DDIV: if (mul_done) begin
          if (dt == '0) begin
            deriv <= '0;
            div_n <= 72'(integral_sum);
            div_d <= 21'(US_PER_S);
            div_start <= 1'b1;
            state <= S_IDIV;
          end else begin
            div_n <= mul_p;
            div_d <= {1'b0, dt};
            div_start <= 1'b1;
            state <= S_MQ;
          end
        end
        S_MQ: if (div_done) begin
          deriv     <= 48'(div_q);
          div_n     <= 72'(integral_sum);
          div_d     <= 21'(US_PER_S);
          div_start <= 1'b1;
          state     <= S_IDIV;
        end
        S_IDIV: if (div_done) begin
          ir        <= (div_r < 0) ? 48'(div_r + 72'(US_PER_S)) : 48'(div_r);
          mul_a     <= 48'(floor_q(div_q, div_r));
          mul_b     <= gain_integ;
          mul_start <= 1'b1;
          state     <= S_MR;
        end
        S_MR: if (mul_done) begin
          sum       <= mul_p;
          mul_a     <= ir;
          mul_b     <= gain_integ;
          mul_start <= 1'b1;
          state     <= S_RDIV;
        end
        S_RDIV: if (mul_done) begin
          div_n     <= mul_p;
          div_d     <= 21'(US_PER_S);
          div_start <= 1'b1;
          state     <= S_MP;
        end
        S_MP: if (div_done) begin
          sum       <= sum + floor_q(div_q, div_r);
          mul_a     <= 48'(err);
          mul_b     <= gain_prop;
          mul_start <= 1'b1;
          state     <= S_MD;
        end
        S_MD: if (mul_done) begin
          sum       <= sum_fin;
          mul_a     <= deriv;
          mul_b     <= gain_deriv;
          mul_start <= 1'b1;
          state     <= S_OUT;
        end
        // keep the full sum so the result can wait for the output register
        S_OUT: if (mul_done) begin
          sum   <= sum_fin;
          state <= S_EMIT;
        end
        S_EMIT: if (emit) begin
          if (sum < 0) begin
            out_data.duty    <= 8'd0;
            out_data.clamped <= 1'b1;
          end else if (sum > 72'(DUTY_MAX * 65536)) begin
            out_data.duty    <= 8'(DUTY_MAX);
            out_data.clamped <= 1'b1;
          end else begin
            out_data.duty    <= sum[23:16];
            out_data.clamped <= clamp;
          end
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_no_cfg_busy: assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready) |-> (state == S_IDLE)) else $error("cfg in busy");
  a_one_unit: assert property (@(posedge clk) disable iff (rst)
    !(mul_start && div_start)) else $error("both units started");
  a_take_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == S_MINT)) else $error("bad start");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid) else $error("result dropped");

endmodule
